>>> rtl/slbb_pkg.sv
// Shared types and constants for the status LED blink and breathe block.
`default_nettype none
package slbb_pkg;

  localparam int ACC_W = 17;
  localparam int PER_W = 16;
  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam int CFG_W = 16;

  localparam logic [PER_W-1:0] BLINK_PERIOD_RST = 16'd500;
  localparam logic [PER_W-1:0] BREATH_STEP_RST  = 16'd10;

  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_BREATHE = 2'd1,
    MODE_BLINK   = 2'd2
  } mode_t;

  typedef enum logic {
    REG_BLINK_PERIOD = 1'b0,
    REG_BREATH_STEP  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage
`default_nettype wire

>>> rtl/slbb_rem.sv
// Bit-serial remainder unit: one restoring compare-and-subtract per cycle.
`default_nettype none
module slbb_rem
  import slbb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ACC_W-1:0] dividend,
  input  wire logic [PER_W-1:0] divisor,
  output rem_status_t           status,
  output logic      [PER_W-1:0] remainder
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] num;
  logic [PER_W-1:0] div;
  logic [PER_W-1:0] rem;
  logic [PER_W-1:0] rem_next;
  logic [PER_W:0]   trial;
  logic [PER_W:0]   diff;

  assign trial    = {rem, num[ACC_W-1]};
  assign diff     = trial - {1'b0, div};
  assign rem_next = (trial >= {1'b0, div}) ? diff[PER_W-1:0] : trial[PER_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ACC_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      div <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[ACC_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign status    = '{busy: busy, done: done};
  assign remainder = rem;

endmodule
`default_nettype wire

>>> rtl/status_led_blink_breathe_top.sv
// Top level of the status LED controller: mode select, blink and breathe logic.
// Usage:
//   Input channel (in_valid/in_ready) takes one tick word: delta_ms,
//   signal_active and client_count. Each tick yields exactly one result word
//   on the output channel (out_valid/out_ready): pin_drive, drive_is_pwm and
//   led_mode. One tick is worked on at a time; in_ready is high only while
//   the sequencer is idle.
//   A tick that does not reach a blink period or breathing step goes from
//   acceptance straight to the finish state, which loads the result. A tick
//   that reaches one runs the 17-bit accumulator through the shared
//   bit-serial remainder unit, one quotient bit per cycle, in the calc state
//   before the finish state; the next tick is taken once the sequencer is idle.
//   The result sits in an output register; the next tick may be accepted
//   while it waits. When the receiver stalls, the finished next result is
//   held until the output register frees up, and in_ready stays low.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 blink
//   period, 1 breathing step); write only while idle.
//   Reset (rst, synchronous) restores solid mode, pin high, brightness zero
//   rising, periods of 500 ms and 10 ms, and empties the output register.
`default_nettype none
module status_led_blink_breathe_top
  import slbb_pkg::*;
#(
  parameter int LED_FULL_SCALE = 255
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [15:0]      delta_ms,
  input  wire logic             signal_active,
  input  wire logic [7:0]       client_count,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [7:0]       pin_drive,
  output logic                  drive_is_pwm,
  output logic      [1:0]       led_mode,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int BW = $clog2(LED_FULL_SCALE + 2) + 1;
  localparam logic [31:0] LED32 = 32'(LED_FULL_SCALE);
  localparam logic [7:0] LED8 = LED32[7:0];
  localparam logic signed [BW-1:0] LED_B = BW'(LED_FULL_SCALE);

  state_t state;
  state_t state_next;

  logic [PER_W-1:0] blink_period;
  logic [PER_W-1:0] breath_step;

  mode_t                 mode_reg;
  logic [PER_W-1:0]      acc;
  logic                  blink_phase;
  logic signed [BW-1:0]  brightness;
  logic                  ramp_up;
  logic [7:0]            pin_level;
  logic                  pin_pwm;

  mode_t                 mode_new;
  logic                  changed;
  logic [ACC_W-1:0]      acc_sum;
  logic [PER_W-1:0]      per;
  logic                  period_hit;
  logic                  accept;
  logic                  rem_start;
  logic                  out_load;
  rem_status_t           rem_st;
  logic [PER_W-1:0]      rem_val;

  logic signed [BW:0]    duty;
  logic signed [BW:0]    duty_sat;
  logic [31:0]           duty32;
  logic signed [BW-1:0]  bri_inc;
  logic signed [BW-1:0]  bri_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period <= BLINK_PERIOD_RST;
      breath_step  <= BREATH_STEP_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BLINK_PERIOD: blink_period <= cfg_data;
        REG_BREATH_STEP:  breath_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (signal_active) begin
      mode_new = MODE_SOLID;
    end else if (client_count != 8'd0) begin
      mode_new = MODE_BREATHE;
    end else begin
      mode_new = MODE_BLINK;
    end
  end

  always_comb begin
    logic [PER_W-1:0] raw;
    raw = (mode_new == MODE_BREATHE) ? breath_step : blink_period;
    per = (raw == '0) ? PER_W'(1) : raw;
  end

  assign changed    = (mode_new != mode_reg);
  assign acc_sum    = changed ? '0 : ({1'b0, acc} + {1'b0, delta_ms});
  assign period_hit = !changed && (mode_new != MODE_SOLID) && (acc_sum >= {1'b0, per});
  assign accept     = in_valid && in_ready;

  assign duty     = {LED_B[BW-1], LED_B} - {brightness[BW-1], brightness};
  assign duty_sat = (duty < 0) ? '0 : ((duty > {LED_B[BW-1], LED_B}) ?
                    {LED_B[BW-1], LED_B} : duty);
  assign duty32   = 32'(duty_sat);
  assign bri_inc  = brightness + BW'(1);
  assign bri_dec  = brightness - BW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = period_hit ? ST_CALC : ST_FINISH;
        end
      end
      ST_CALC: begin
        if (rem_st.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_CALC:   ;
      ST_FINISH: out_load = !out_valid || out_ready;
      default:   ;
    endcase
  end

  assign rem_start = accept && period_hit;

  slbb_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (acc_sum),
    .divisor   (per),
    .status    (rem_st),
    .remainder (rem_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_SOLID;
      acc         <= '0;
      blink_phase <= 1'b0;
      brightness  <= '0;
      ramp_up     <= 1'b1;
      pin_level   <= LED8;
      pin_pwm     <= 1'b0;
    end else if (accept) begin
      mode_reg <= mode_new;
      if (mode_new == MODE_SOLID) begin
        acc       <= '0;
        pin_level <= LED8;
        pin_pwm   <= 1'b0;
      end else if (changed) begin
        acc       <= '0;
        pin_level <= 8'd0;
        pin_pwm   <= 1'b0;
      end else if (period_hit) begin
        if (mode_new == MODE_BLINK) begin
          blink_phase <= !blink_phase;
          pin_level   <= blink_phase ? LED8 : 8'd0;
          pin_pwm     <= 1'b0;
        end else begin
          pin_level <= duty32[7:0];
          pin_pwm   <= 1'b1;
          if (ramp_up) begin
            brightness <= bri_inc;
            if (bri_inc > LED_B) begin
              ramp_up <= 1'b0;
            end
          end else begin
            brightness <= bri_dec;
            if (bri_dec < 0) begin
              ramp_up <= 1'b1;
            end
          end
        end
      end else begin
        acc <= acc_sum[PER_W-1:0];
      end
    end else if (state == ST_CALC && rem_st.done) begin
      acc <= rem_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pin_drive    <= pin_level;
      drive_is_pwm <= pin_pwm;
      led_mode     <= mode_reg;
    end
  end

endmodule
`default_nettype wire

>>> rtl/slbb_checker.sv
// Port-level checks for the status LED controller, bound to the top level.
`default_nettype none
module slbb_checker
  import slbb_pkg::*;
#(
  parameter int LED_FULL_SCALE = 255
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [7:0]       pin_drive,
  input wire logic             drive_is_pwm,
  input wire logic [1:0]       led_mode
);

  localparam logic [31:0] LED32 = 32'(LED_FULL_SCALE);
  localparam logic [7:0] LED8 = LED32[7:0];

  a_solid_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_mode == MODE_SOLID |-> pin_drive == LED8 && !drive_is_pwm)
    else $error("solid mode word not digital high");

  a_blink_digital: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_mode == MODE_BLINK |-> !drive_is_pwm)
    else $error("blink mode word marked as pwm");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pin_drive) &&
      $stable(drive_is_pwm) && $stable(led_mode))
    else $error("stalled output word changed");

endmodule

bind status_led_blink_breathe_top slbb_checker #(.LED_FULL_SCALE(LED_FULL_SCALE)) u_chk (.*);
`default_nettype wire

>>> verif/status_led_blink_breathe_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the status LED blink and breathe controller.
module status_led_blink_breathe_top_test;
  import slbb_pkg::*;

  localparam int FULL_SCALE = 255;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic [15:0] delta;
    logic        sig;
    logic [7:0]  clients;
  } tick_t;

  typedef struct {
    logic [7:0] drive;
    logic       pwm;
    mode_t      mode;
  } led_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [15:0]      delta_ms = '0;
  logic             signal_active = 1'b0;
  logic [7:0]       client_count = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       pin_drive;
  logic             drive_is_pwm;
  logic [1:0]       led_mode;
  logic             cfg_we = 1'b0;
  reg_idx_t         cfg_index = REG_BLINK_PERIOD;
  logic [CFG_W-1:0] cfg_data = '0;

  // predicted controller state and register copies
  logic [15:0] blink_cfg = BLINK_PERIOD_RST;
  logic [15:0] breath_cfg = BREATH_STEP_RST;
  mode_t       led_state = MODE_SOLID;
  logic [31:0] elapsed = '0;
  logic        blink_ph = 1'b0;
  int          bright = 0;
  logic        rising = 1'b1;
  int          level = FULL_SCALE;
  logic        pwm_on = 1'b0;

  tick_t       tick_q[$];
  led_word_t   led_q[$];
  tick_t       shown;
  led_word_t   want;
  int          ticks_loaded = 0;
  int          accepted_ticks = 0;
  int          checked_ticks = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  int          hold_left = 0;

  status_led_blink_breathe_top #(
    .LED_FULL_SCALE(FULL_SCALE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .delta_ms(delta_ms),
    .signal_active(signal_active),
    .client_count(client_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pin_drive(pin_drive),
    .drive_is_pwm(drive_is_pwm),
    .led_mode(led_mode),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_miss(input string what, input int got, input int want_v);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at word %0d: %s got %0d, want %0d", checked_ticks, what, got, want_v);
    end
  endtask

  // advance the LED state by one tick and queue the word it produces
  task automatic step_led(input tick_t t);
    mode_t       nxt;
    logic [31:0] per;
    int          duty;
    led_word_t   w;
    if (t.sig) nxt = MODE_SOLID;
    else if (t.clients != 0) nxt = MODE_BREATHE;
    else nxt = MODE_BLINK;
    if (nxt != led_state) begin
      level = 0;
      pwm_on = 1'b0;
      elapsed = '0;
      led_state = nxt;
    end else begin
      elapsed = elapsed + t.delta;
    end
    case (led_state)
      MODE_BREATHE: begin
        per = (breath_cfg == 0) ? 32'd1 : breath_cfg;
        if (elapsed >= per) begin
          duty = FULL_SCALE - bright;
          if (duty < 0) duty = 0;
          if (duty > FULL_SCALE) duty = FULL_SCALE;
          level = duty;
          pwm_on = 1'b1;
          if (rising) begin
            bright++;
            if (bright > FULL_SCALE) rising = 1'b0;
          end else begin
            bright--;
            if (bright < 0) rising = 1'b1;
          end
          elapsed = elapsed % per;
        end
      end
      MODE_BLINK: begin
        per = (blink_cfg == 0) ? 32'd1 : blink_cfg;
        if (elapsed >= per) begin
          blink_ph = ~blink_ph;
          level = blink_ph ? 0 : FULL_SCALE;
          pwm_on = 1'b0;
          elapsed = elapsed % per;
        end
      end
      default: begin
        level = FULL_SCALE;
        pwm_on = 1'b0;
      end
    endcase
    w.drive = level[7:0];
    w.pwm = pwm_on;
    w.mode = led_state;
    led_q.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_led(shown);
        accepted_ticks <= accepted_ticks + 1;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          shown = tick_q.pop_front();
          in_valid <= 1'b1;
          delta_ms <= shown.delta;
          signal_active <= shown.sig;
          client_count <= shown.clients;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (checked_ticks < accepted_ticks) begin
          want = led_q.pop_front();
          if (pin_drive !== want.drive) report_miss("pin_drive", pin_drive, want.drive);
          if (drive_is_pwm !== want.pwm) report_miss("drive_is_pwm", drive_is_pwm, want.pwm);
          if (led_mode !== want.mode) report_miss("led_mode", led_mode, want.mode);
          checked_ticks <= checked_ticks + 1;
        end else begin
          report_miss("unexpected word, pin_drive", pin_drive, -1);
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic load_tick(input logic [15:0] d, input logic s, input logic [7:0] c);
    tick_t t;
    t.delta = d;
    t.sig = s;
    t.clients = c;
    tick_q.push_back(t);
    ticks_loaded++;
  endtask

  task automatic drain_all();
    while (accepted_ticks != ticks_loaded || checked_ticks != accepted_ticks) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLINK_PERIOD) blink_cfg = val;
    else breath_cfg = val;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_delta(input logic [15:0] per);
    int p;
    int d;
    p = (per == 0) ? 1 : per;
    case ($urandom_range(3))
      0: d = $urandom_range(3);
      1: d = p + int'($urandom_range(4)) - 2;
      2: d = $urandom_range(p);
      default: d = $urandom_range(65535);
    endcase
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[15:0];
  endfunction

  // runs of one mode with deltas around its period, plus some noise ticks
  task automatic load_runs(input int count);
    int          left;
    int          len;
    int          pick;
    mode_t       m;
    logic [15:0] per;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(9);
      m = (pick < 2) ? MODE_SOLID : (pick < 6) ? MODE_BREATHE : MODE_BLINK;
      len = $urandom_range(30, 1);
      per = (m == MODE_BREATHE) ? breath_cfg : blink_cfg;
      for (int i = 0; i < len && left > 0; i++) begin
        if ($urandom_range(9) == 0) begin
          load_tick(16'($urandom_range(65535)), 1'($urandom_range(1)),
                    8'($urandom_range(255)));
        end else begin
          case (m)
            MODE_SOLID: load_tick(pick_delta(per), 1'b1, 8'($urandom_range(255)));
            MODE_BREATHE: load_tick(pick_delta(per), 1'b0, 8'($urandom_range(255, 1)));
            default: load_tick(pick_delta(per), 1'b0, 8'd0);
          endcase
        end
        left--;
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("status_led_blink_breathe_top_test: errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed ticks at reset periods of 500 and 10
    load_tick(16'd0, 1'b1, 8'd0);
    load_tick(16'hFFFF, 1'b1, 8'hFF);
    load_tick(16'd0, 1'b0, 8'd1);
    load_tick(16'd10, 1'b0, 8'hFF);
    load_tick(16'hFFFF, 1'b0, 8'd7);
    load_tick(16'd4, 1'b0, 8'd1);
    load_tick(16'd0, 1'b0, 8'd0);
    load_tick(16'd499, 1'b0, 8'd0);
    load_tick(16'd1, 1'b0, 8'd0);
    load_tick(16'd500, 1'b0, 8'd0);
    load_tick(16'hFFFF, 1'b0, 8'd0);
    load_tick(16'd3, 1'b0, 8'h80);
    load_tick(16'hAAAA, 1'b1, 8'h55);
    load_tick(16'h5555, 1'b1, 8'hAA);
    load_tick(16'd0, 1'b0, 8'd0);
    load_tick(16'd1, 1'b0, 8'h80);
    load_tick(16'd0, 1'b1, 8'd0);
    drain_all();

    // sweep brightness through both ends, one step per tick
    write_reg(REG_BLINK_PERIOD, 16'd1);
    write_reg(REG_BREATH_STEP, 16'd1);
    for (int i = 0; i < 530; i++) begin
      load_tick(16'($urandom_range(4, 1)), 1'b0, 8'($urandom_range(255, 1)));
    end
    drain_all();

    write_reg(REG_BLINK_PERIOD, 16'hFFFF);
    write_reg(REG_BREATH_STEP, 16'hFFFF);
    send_idle_pct = 67;
    recv_stall_pct = 0;
    load_runs(250);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    drain_all();

    write_reg(REG_BLINK_PERIOD, 16'd0);
    write_reg(REG_BREATH_STEP, 16'd0);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    load_runs(250);
    drain_all();

    write_reg(REG_BLINK_PERIOD, 16'($urandom_range(1000, 2)));
    write_reg(REG_BREATH_STEP, 16'($urandom_range(1000, 2)));
    send_idle_pct = 7;
    recv_stall_pct = 7;
    load_runs(250);
    drain_all();

    write_reg(REG_BLINK_PERIOD, 16'($urandom_range(65535, 1)));
    write_reg(REG_BREATH_STEP, 16'($urandom_range(65535, 1)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_runs(250);
    drain_all();

    if (errors == 0) begin
      $display("status_led_blink_breathe_top_test: clean");
    end else begin
      $display("status_led_blink_breathe_top_test: errors");
    end
    $finish;
  end

endmodule
